// ===== hw/rtl/wis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wis_pkg;

  // Pixel fields carried by one input word.
  localparam int unsigned FieldImages   = 4;
  localparam int unsigned ImageCountDef = 4;

  localparam int unsigned PixW    = 8;
  localparam int unsigned WeightW = 16;
  // signed 16 x unsigned 8 fits in 24 signed bits
  localparam int unsigned ProdW   = 24;
  // sum of up to four products, total of up to four weights
  localparam int unsigned SumW    = 27;
  localparam int unsigned TotW    = 19;
  // quotient bits, divisor magnitude, dividend magnitude
  localparam int unsigned QuoW    = 8;
  localparam int unsigned DivW    = 18;
  localparam int unsigned MagW    = DivW + QuoW;

  localparam int unsigned InDataW  = FieldImages * PixW;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWeightA   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWeightB   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWeightC   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWeightD   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNormalize = 3'd4;

  // Divisor used when normalization is off or the weight total is zero:
  // drops the eight fraction bits of Q8.8.
  localparam logic signed [TotW-1:0] FracDivisor = 19'sd256;

  localparam logic [PixW-1:0] PixMax = 8'd255;
  localparam logic [PixW-1:0] PixMin = 8'd0;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic signed [TotW-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wis_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wis_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [wis_pkg::WeightW-1:0]   weight_i,
  input  wire logic        [wis_pkg::PixW-1:0]      pixel_i,
  output logic signed      [wis_pkg::ProdW-1:0]     prod_o
);

  logic signed [wis_pkg::ProdW:0]   prod_full;
  logic signed [wis_pkg::ProdW-1:0] prod_d, prod_q;

  always_comb begin
    prod_full = weight_i * $signed({1'b0, pixel_i});
    prod_d    = prod_full[wis_pkg::ProdW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wis_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wis_merge #(
  parameter int unsigned LaneCount = wis_pkg::FieldImages
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire logic signed [wis_pkg::ProdW-1:0]    prods_i   [LaneCount],
  input  wire logic signed [wis_pkg::WeightW-1:0]  weights_i [LaneCount],
  input  wire logic                                normalize_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output wis_pkg::div_req_t                        req_o
);

  logic                   valid_q;
  logic signed [wis_pkg::SumW-1:0] sum;
  logic signed [wis_pkg::TotW-1:0] total;
  wis_pkg::div_req_t      req_d, req_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    sum   = '0;
    total = '0;
    for (int l = 0; l < LaneCount; l++) begin
      sum   = sum + wis_pkg::SumW'(prods_i[l]);
      total = total + wis_pkg::TotW'(weights_i[l]);
    end
    req_d.sum     = sum;
    req_d.divisor = (normalize_i && total != '0) ? total : wis_pkg::FracDivisor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wis_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wis_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire wis_pkg::div_req_t          req_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [wis_pkg::PixW-1:0]        pixel_o,
  output logic                            clamped_o
);

  localparam int unsigned Stages = wis_pkg::QuoW + 1;

  // stage 0 takes magnitudes, stages 1..QuoW each settle one quotient bit
  logic                          valid_q [Stages];
  logic                          neg_q   [Stages];
  logic                          over_q  [Stages];
  logic [wis_pkg::MagW-1:0]      rem_q   [Stages];
  logic [wis_pkg::DivW-1:0]      dv_q    [Stages];
  logic [wis_pkg::QuoW-1:0]      quo_q   [Stages];
  logic                          rdy     [Stages+1];

  logic                          out_valid_q;
  logic [wis_pkg::PixW-1:0]      pix_q, pix_d;
  logic                          clamp_q, clamp_d;

  assign rdy[Stages] = !out_valid_q || ready_i;
  assign ready_o     = rdy[0];

  // Stage 0: signs and magnitudes, early overflow test
  logic signed [wis_pkg::SumW-1:0] s_abs;
  logic signed [wis_pkg::TotW-1:0] d_abs;
  logic [wis_pkg::MagW-1:0]        s_mag;
  logic [wis_pkg::DivW-1:0]        d_mag;

  always_comb begin
    s_abs = req_i.sum[wis_pkg::SumW-1] ? -req_i.sum : req_i.sum;
    d_abs = req_i.divisor[wis_pkg::TotW-1] ? -req_i.divisor : req_i.divisor;
    s_mag = s_abs[wis_pkg::MagW-1:0];
    d_mag = d_abs[wis_pkg::DivW-1:0];
  end

  assign rdy[0] = !valid_q[0] || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      neg_q[0]  <= req_i.sum[wis_pkg::SumW-1] ^ req_i.divisor[wis_pkg::TotW-1];
      over_q[0] <= s_mag >= {d_mag, {wis_pkg::QuoW{1'b0}}};
      rem_q[0]  <= s_mag;
      dv_q[0]   <= d_mag;
      quo_q[0]  <= '0;
    end
  end

  // Restoring steps, most significant quotient bit first
  for (genvar j = 1; j < Stages; j++) begin : g_step
    localparam int unsigned Bit = wis_pkg::QuoW - j;
    logic [wis_pkg::MagW-1:0] shifted;
    logic                     take;
    logic [wis_pkg::QuoW-1:0] quo_d;

    always_comb begin
      shifted    = wis_pkg::MagW'(dv_q[j-1]) << Bit;
      take       = rem_q[j-1] >= shifted;
      quo_d      = quo_q[j-1];
      quo_d[Bit] = take;
    end

    assign rdy[j] = !valid_q[j] || rdy[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        valid_q[j] <= valid_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && valid_q[j-1]) begin
        neg_q[j]  <= neg_q[j-1];
        over_q[j] <= over_q[j-1];
        rem_q[j]  <= take ? rem_q[j-1] - shifted : rem_q[j-1];
        dv_q[j]   <= dv_q[j-1];
        quo_q[j]  <= quo_d;
      end
    end
  end

  // Clamp: negative nonzero quotients go to 0, large positive ones to 255
  always_comb begin
    pix_d   = quo_q[Stages-1];
    clamp_d = 1'b0;
    if (neg_q[Stages-1]) begin
      pix_d   = wis_pkg::PixMin;
      clamp_d = over_q[Stages-1] || (quo_q[Stages-1] != '0);
    end else if (over_q[Stages-1]) begin
      pix_d   = wis_pkg::PixMax;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[Stages]) begin
      out_valid_q <= valid_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Stages] && valid_q[Stages-1]) begin
      pix_q   <= pix_d;
      clamp_q <= clamp_d;
    end
  end

  assign valid_o   = out_valid_q;
  assign pixel_o   = pix_q;
  assign clamped_o = clamp_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> dv_q[0] != '0)
    else $error("zero divisor entered the quotient pipeline");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[Stages-1] && !over_q[Stages-1]) |->
      rem_q[Stages-1] < wis_pkg::MagW'(dv_q[Stages-1]))
    else $error("final remainder not below divisor");

  a_clamp_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clamp_q) |-> (pix_q == wis_pkg::PixMin || pix_q == wis_pkg::PixMax))
    else $error("clamped word not at a range limit");

endmodule
`default_nettype wire

// ===== hw/rtl/weighted_image_sum_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Weighted blend of co-located pixels: each input word carries one 8-bit pixel per
// image, each lane multiplies its pixel by a signed Q8.8 weight, and the merge stage
// adds the products. With normalize set and a nonzero weight total the sum is divided
// by that total, otherwise by 256, truncating toward zero; the result is clamped to
// 0..255 and the clamp is flagged. One word is accepted every clock while the output
// is taken. The pipeline registers are lane multiply, merge add, sign stage, eight
// pipelined quotient-bit stages and output register. The pipelined quotient unit, one
// bit per stage, sets the rate. Write the weights and normalize only while idle.
module weighted_image_sum_core #(
  parameter int unsigned ImageCount = wis_pkg::ImageCountDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [wis_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [wis_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_a, pixel_b, pixel_c, pixel_d
  input  wire logic [wis_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // blended_pixel, clamped, zero fill
  output logic [wis_pkg::OutDataW-1:0]          m_axis_tdata
);

  localparam int unsigned LaneCount =
    (ImageCount < wis_pkg::FieldImages) ? ImageCount : wis_pkg::FieldImages;

  logic signed [wis_pkg::WeightW-1:0] weight_q [LaneCount];
  logic                               normalize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LaneCount; l++) begin
        weight_q[l] <= '0;
      end
      normalize_q <= 1'b1;
    end else if (cfg_we_i) begin
      for (int l = 0; l < LaneCount; l++) begin
        if (cfg_idx_i == wis_pkg::CfgIdxW'(wis_pkg::RegWeightA + l)) begin
          weight_q[l] <= $signed(cfg_wdata_i);
        end
      end
      if (cfg_idx_i == wis_pkg::RegNormalize) begin
        normalize_q <= cfg_wdata_i[0];
      end
    end
  end

  // Lane stage
  logic lane_valid_q;
  logic lane_ready;
  logic merge_ready;
  logic lane_load;
  logic signed [wis_pkg::ProdW-1:0] prod [LaneCount];

  assign lane_ready    = !lane_valid_q || merge_ready;
  assign s_axis_tready = lane_ready;
  assign lane_load     = lane_ready && s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (lane_ready) begin
      lane_valid_q <= s_axis_tvalid;
    end
  end

  for (genvar l = 0; l < LaneCount; l++) begin : g_lane
    wis_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_load),
      .weight_i (weight_q[l]),
      .pixel_i  (s_axis_tdata[l*wis_pkg::PixW +: wis_pkg::PixW]),
      .prod_o   (prod[l])
    );
  end

  logic              merge_valid;
  logic              div_ready;
  wis_pkg::div_req_t div_req;

  wis_merge #(
    .LaneCount (LaneCount)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lane_valid_q),
    .ready_o     (merge_ready),
    .prods_i     (prod),
    .weights_i   (weight_q),
    .normalize_i (normalize_q),
    .valid_o     (merge_valid),
    .ready_i     (div_ready),
    .req_o       (div_req)
  );

  logic [wis_pkg::PixW-1:0] blended_pixel;
  logic                     clamped;

  wis_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (merge_valid),
    .ready_o   (div_ready),
    .req_i     (div_req),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .pixel_o   (blended_pixel),
    .clamped_o (clamped)
  );

  assign m_axis_tdata = {{(wis_pkg::OutDataW - wis_pkg::PixW - 1){1'b0}},
                         clamped, blended_pixel};

  // An empty output register lets ready ripple back through every stage.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire

// ===== tb/sv/weighted_image_sum_core_tb.sv =====
`timescale 1ns / 1ps
module weighted_image_sum_core_tb;
  import wis_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    logic [PixW-1:0] blended;
    logic            clamped;
  } blend_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // pixel_a, pixel_b, pixel_c, pixel_d
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // blended_pixel, clamped, zero fill
  logic [OutDataW-1:0] m_axis_tdata;

  // Local copy of the blend registers
  logic signed [WeightW-1:0] weight_copy [FieldImages];
  logic                      normalize_copy;

  blend_result_t blend_q [$];
  int unsigned   errors = 0;
  int unsigned   words_in = 0;
  int unsigned   results_out = 0;
  int unsigned   settings_used = 0;
  int unsigned   cycles = 0;
  bit            gaps_on = 1'b0;
  bit            stall_on = 1'b0;
  int unsigned   hold_req = 0;

  weighted_image_sum_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, blend_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic blend_result_t predict_blend(input logic [InDataW-1:0] word);
    blend_result_t res;
    longint        sum;
    longint        total;
    longint        quo;
    sum = 0;
    total = 0;
    for (int k = 0; k < int'(ImageCountDef) && k < int'(FieldImages); k++) begin
      sum += longint'(weight_copy[k]) * longint'(word[k*PixW +: PixW]);
      total += longint'(weight_copy[k]);
    end
    // SV division truncates toward zero on signed operands
    if (normalize_copy && total != 0) quo = sum / total;
    else quo = sum / 256;
    if (quo < 0) begin
      res.blended = PixMin;
      res.clamped = 1'b1;
    end else if (quo > 255) begin
      res.blended = PixMax;
      res.clamped = 1'b1;
    end else begin
      res.blended = quo[PixW-1:0];
      res.clamped = 1'b0;
    end
    return res;
  endfunction

  // Predict at the input handshake; registers only change while idle.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      blend_q.push_back(predict_blend(s_axis_tdata));
      words_in++;
    end
  end

  always @(posedge clk_i) begin
    blend_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (blend_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = blend_q.pop_front();
        if (m_axis_tdata[PixW-1:0] !== want.blended) begin
          $display("%0t: blended_pixel expected %0d actual %0d", $time, want.blended,
                   m_axis_tdata[PixW-1:0]);
          errors++;
        end
        if (m_axis_tdata[PixW] !== want.clamped) begin
          $display("%0t: clamped expected %0d actual %0d", $time, want.clamped,
                   m_axis_tdata[PixW]);
          errors++;
        end
        if (m_axis_tdata[OutDataW-1:PixW+1] !== '0) begin
          $display("%0t: fill bits expected 0 actual %h", $time,
                   m_axis_tdata[OutDataW-1:PixW+1]);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus long hold-offs on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [InDataW-1:0] word);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_pixels(input logic [PixW-1:0] pa, input logic [PixW-1:0] pb,
                             input logic [PixW-1:0] pc, input logic [PixW-1:0] pd);
    send_word({pd, pc, pb, pa});
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (blend_q.size() != 0) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it once the sequence ends.
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegWeightA, RegWeightB, RegWeightC, RegWeightD: weight_copy[idx] = val;
      RegNormalize: normalize_copy = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_blend(input logic [WeightW-1:0] wa, input logic [WeightW-1:0] wb,
                               input logic [WeightW-1:0] wc, input logic [WeightW-1:0] wd,
                               input logic norm);
    wait_drained();
    set_reg(RegWeightA, wa);
    set_reg(RegWeightB, wb);
    set_reg(RegWeightC, wc);
    set_reg(RegWeightD, wd);
    set_reg(RegNormalize, {{(CfgDataW-1){1'b0}}, norm});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return WeightW'($urandom_range(0, 512));
      4: return -WeightW'($urandom_range(0, 512));
      default: return WeightW'($urandom);
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return PixMin;
      1: return PixMax;
      default: return PixW'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    // zero weights with normalize on: total is zero, so the plain scale applies
    send_pixels(8'd255, 8'd255, 8'd255, 8'd255);
    settings_used++;
  endtask

  task automatic test_unit_weights();
    program_blend(16'sd256, 16'sd256, 16'sd256, 16'sd256, 1'b1);
    send_pixels(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixels(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixels(8'd0, 8'd255, 8'd128, 8'd1);
  endtask

  task automatic test_normalize_off();
    program_blend(16'sd256, 16'sd256, 16'sd256, 16'sd256, 1'b0);
    send_pixels(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixels(8'd10, 8'd20, 8'd30, 8'd40);
    send_pixels(8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_weight_extremes();
    program_blend(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixels(8'd255, 8'd7, 8'd7, 8'd7);
    send_pixels(8'd0, 8'd255, 8'd255, 8'd255);
    program_blend(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixels(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixels(8'd1, 8'd0, 8'd0, 8'd0);
    program_blend(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_pixels(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixels(8'd3, 8'd200, 8'd17, 8'd90);
    program_blend(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_pixels(8'd254, 8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_zero_total();
    // normalize on, but the weights cancel
    program_blend(16'sd256, -16'sd256, 16'sd512, -16'sd512, 1'b1);
    send_pixels(8'd200, 8'd100, 8'd0, 8'd0);
    send_pixels(8'd0, 8'd255, 8'd0, 8'd0);
  endtask

  task automatic test_truncation();
    // quotients above -1 truncate to zero unclamped; -1.5 clamps to 0
    program_blend(16'sd300, -16'sd100, 16'sd0, 16'sd0, 1'b1);
    send_pixels(8'd0, 8'd1, 8'd0, 8'd0);
    send_pixels(8'd0, 8'd3, 8'd0, 8'd0);
    program_blend(16'sd0, -16'sd100, 16'sd0, 16'sd0, 1'b0);
    send_pixels(8'd0, 8'd1, 8'd0, 8'd0);
    program_blend(16'sd256, -16'sd512, 16'sd0, 16'sd0, 1'b1);
    send_pixels(8'd3, 8'd2, 8'd0, 8'd0);
  endtask

  task automatic test_unused_index();
    program_blend(16'sd128, 16'sd64, 16'sd32, 16'sd32, 1'b1);
    // writes past the register list must leave everything untouched
    for (int i = RegNormalize + 1; i < (1 << CfgIdxW); i++)
      set_reg(CfgIdxW'(i), 16'hffff);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_pixels(8'd255, 8'd128, 8'd64, 8'd0);
    send_pixels(8'd9, 8'd250, 8'd33, 8'd170);
  endtask

  task automatic test_random_blends(input int unsigned phases, input int unsigned words);
    for (int unsigned p = 0; p < phases; p++) begin
      program_blend(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                    $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        set_reg(CfgIdxW'($urandom_range(RegNormalize + 1, (1 << CfgIdxW) - 1)),
                CfgDataW'($urandom));
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      for (int unsigned n = 0; n < words; n++)
        send_pixels(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
    end
  endtask

  task automatic test_backpressure();
    program_blend(16'sd200, 16'sd100, -16'sd50, 16'sd6, 1'b1);
    gaps_on = 1'b0;
    hold_req = 150;
    for (int unsigned n = 0; n < 60; n++)
      send_pixels(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
  endtask

  initial begin
    weight_copy = '{default: '0};
    normalize_copy = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_unit_weights();
    test_normalize_off();
    test_weight_extremes();
    test_zero_total();
    test_truncation();
    test_unused_index();

    gaps_on = 1'b1;
    stall_on = 1'b1;
    test_random_blends(6, 40);
    test_backpressure();

    // last stretch runs at full rate on both sides
    gaps_on = 1'b0;
    stall_on = 1'b0;
    test_random_blends(2, 40);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (blend_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, blend_q.size());
      errors++;
    end
    $display("Blended %0d pixel sets into %0d results across %0d weight settings,",
             words_in, results_out, settings_used);
    $display("with random gaps, output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
